// ===== sv/savitzky_golay_fir_assert.svh =====
// ----------------------------------------------------------------------------
// savitzky_golay_fir_assert.svh
// assertion macros for the checker file of the smoother block
// ----------------------------------------------------------------------------
`ifndef SAVITZKY_GOLAY_FIR_ASSERT_SVH
`define SAVITZKY_GOLAY_FIR_ASSERT_SVH

// property checked at every rising clock edge, quiet during reset
`define SAVGOL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a rising clock edge
`define SAVGOL_NEVER(lbl, cond, msg) \
	`SAVGOL_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/savgol_pkg.sv =====
// ----------------------------------------------------------------------------
// savgol_pkg
// shared widths, field offsets, saturation limits, operation codes and fsm type
// ----------------------------------------------------------------------------
package savgol_pkg;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int WEIGHT_W = 18;
	localparam int DERIV_W  = 2;
	localparam int TAP_IN_W = 4;
	localparam int FRAC_W   = 15;
	localparam int OUT_W    = 32;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;

	// input tdata layout, lowest bit first
	localparam int S_TDATA_W  = 48;
	localparam int SAMPLE_LSB = 0;
	localparam int DERIV_LSB  = SAMPLE_LSB + SAMPLE_W;
	localparam int TAP_LSB    = DERIV_LSB + DERIV_W;
	localparam int WEIGHT_LSB = TAP_LSB + TAP_IN_W;

	// output tdata width
	localparam int M_TDATA_W = 32;

	// saturation limits
	localparam logic [OUT_W-1:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

	// operation codes carried in s_tuser
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

// ===== sv/savitzky_golay_fir.sv =====
// ----------------------------------------------------------------------------
// savitzky_golay_fir
// sliding-window polynomial smoother / differentiator with one shared mac
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser selects the transaction kind. A load transaction
// writes one Q2.15 weight into the bank given by deriv_order at weight_tap and
// gives no result and the block stays ready. A push shifts a sample into
// the window (the first push after reset fills the whole window) and returns
// one result on the output stream (m_*): the window dot product with the
// chosen bank, shifted right by 15 with floor rounding and saturated to 32
// bits, with m_tuser high while fewer than WINDOW samples have been pushed.
// A push steps through all WINDOW taps one per cycle, through the single 18x24
// multiplier and the weight memory read port; the pipeline then drains, the
// sequencer sees it empty and the output register is loaded. Only then is the
// next transaction taken. A push with a bank above MAX_DERIV skips the taps
// and loads its zero result into the output register from the final state.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new transaction is taken while it waits; a stalled
// receiver holds the next result back in the final state.
// Reset clears the window, the sample count and the handshake state. Weights
// are not cleared and must be loaded before they are used.
// ----------------------------------------------------------------------------
module savitzky_golay_fir #(
	parameter int WINDOW    = 15,
	parameter int MAX_DERIV = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: sample[23:0], deriv_order[25:24], weight_tap[29:26],
	//          weight_value[47:30]
	input  logic [savgol_pkg::S_TDATA_W-1:0]    s_tdata,
	// s_tuser: operation[0]
	input  logic                                s_tuser,
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: filtered_value[31:0]
	output logic [savgol_pkg::M_TDATA_W-1:0]    m_tdata,
	// m_tuser: status[0]
	output logic                                m_tuser
);

	localparam int BANKS  = MAX_DERIV + 1;
	localparam int DEPTH  = BANKS * WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int TAP_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int ACC_W  = savgol_pkg::PROD_W + $clog2(WINDOW);
	localparam int SW     = savgol_pkg::SAMPLE_W;
	localparam int WW     = savgol_pkg::WEIGHT_W;

	// field unpacking
	logic signed [SW-1:0]                   in_sample;
	logic [savgol_pkg::DERIV_W-1:0]         in_deriv;
	logic [savgol_pkg::TAP_IN_W-1:0]        in_tap;
	logic signed [WW-1:0]                   in_weight;
	logic                                   in_acc;
	logic                                   bank_ok;
	logic                                   tap_ok;
	logic [ADDR_W-1:0]                      bank_base;

	// state
	savgol_pkg::state_t                     state_q;
	logic signed [SW-1:0]                   win_q [WINDOW];
	logic [CNT_W-1:0]                       cnt_q;
	logic [TAP_W-1:0]                       tap_q;
	logic [ADDR_W-1:0]                      rd_addr_q;
	logic                                   bad_q;
	logic signed [WW-1:0]                   wmem [DEPTH];

	// mac pipeline
	logic signed [WW-1:0]                   wt_s1;
	logic signed [SW-1:0]                   smp_s1;
	logic                                   vld_s1;
	logic signed [savgol_pkg::PROD_W-1:0]   prod_s2;
	logic                                   vld_s2;
	logic signed [ACC_W-1:0]                acc_q;

	// result
	logic signed [ACC_W-1:0]                acc_sh;
	logic [ACC_W-savgol_pkg::OUT_W:0]       acc_hi;
	logic [savgol_pkg::OUT_W-1:0]           sat_val;
	logic                                   out_load;
	logic                                   m_tvalid_q;
	logic [savgol_pkg::OUT_W-1:0]           m_tdata_q;
	logic                                   m_tuser_q;

	// input field decode
	assign in_sample = s_tdata[savgol_pkg::SAMPLE_LSB +: SW];
	assign in_deriv  = s_tdata[savgol_pkg::DERIV_LSB +: savgol_pkg::DERIV_W];
	assign in_tap    = s_tdata[savgol_pkg::TAP_LSB +: savgol_pkg::TAP_IN_W];
	assign in_weight = s_tdata[savgol_pkg::WEIGHT_LSB +: WW];
	assign s_tready  = (state_q == savgol_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign bank_ok   = (int'(in_deriv) <= MAX_DERIV);
	assign tap_ok    = (int'(in_tap) < WINDOW);
	assign bank_base = ADDR_W'(in_deriv) * ADDR_W'(WINDOW);

	// weight memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == savgol_pkg::OP_LOAD) && bank_ok && tap_ok) begin
			wmem[bank_base + ADDR_W'(in_tap)] <= in_weight;
		end
		wt_s1 <= wmem[rd_addr_q];
	end

	// sample window: shift in on push, rotate one tap per mac cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_acc && (s_tuser == savgol_pkg::OP_PUSH)) begin
			if (cnt_q == '0) begin
				for (int i = 0; i < WINDOW; i++) begin
					win_q[i] <= in_sample;
				end
			end else begin
				for (int i = 0; i < WINDOW - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WINDOW-1] <= in_sample;
			end
		end else if (state_q == savgol_pkg::ST_RUN) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW-1] <= win_q[0];
		end
	end

	// mac datapath, the tap for the current mac cycle sits at window position zero
	always_ff @(posedge clk) begin
		smp_s1  <= win_q[0];
		prod_s2 <= wt_s1 * smp_s1;
		if (in_acc) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= savgol_pkg::ST_IDLE;
			cnt_q     <= '0;
			tap_q     <= '0;
			rd_addr_q <= '0;
			bad_q     <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			vld_s1 <= (state_q == savgol_pkg::ST_RUN);
			vld_s2 <= vld_s1;
			case (state_q)
				savgol_pkg::ST_IDLE: begin
					if (in_acc && (s_tuser == savgol_pkg::OP_PUSH)) begin
						if (cnt_q != CNT_W'(WINDOW)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						tap_q     <= '0;
						rd_addr_q <= bank_base;
						bad_q     <= !bank_ok;
						state_q   <= bank_ok ? savgol_pkg::ST_RUN : savgol_pkg::ST_DONE;
					end
				end
				savgol_pkg::ST_RUN: begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
					tap_q     <= tap_q + TAP_W'(1);
					if (tap_q == TAP_W'(WINDOW - 1)) begin
						state_q <= savgol_pkg::ST_DRAIN;
					end
				end
				savgol_pkg::ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= savgol_pkg::ST_DONE;
					end
				end
				savgol_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= savgol_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= savgol_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// floor shift and saturation
	always_comb begin
		acc_sh = acc_q >>> savgol_pkg::FRAC_W;
		acc_hi = acc_sh[ACC_W-1:savgol_pkg::OUT_W-1];
		if (bad_q) begin
			sat_val = '0;
		end else if ((acc_hi == '0) || (acc_hi == '1)) begin
			sat_val = acc_sh[savgol_pkg::OUT_W-1:0];
		end else if (acc_sh[ACC_W-1]) begin
			sat_val = savgol_pkg::SAT_MIN;
		end else begin
			sat_val = savgol_pkg::SAT_MAX;
		end
	end

	// output register, loaded when empty or being drained
	assign out_load = (state_q == savgol_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= sat_val;
			m_tuser_q <= (cnt_q < CNT_W'(WINDOW));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/savgol_checker.sv =====
// ----------------------------------------------------------------------------
// savgol_checker
// port-level checks of the smoother handshakes, bound to the top level
// ----------------------------------------------------------------------------
`include "savitzky_golay_fir_assert.svh"

module savgol_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [savgol_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser
);

	logic push_acc;
	logic load_acc;

	// input transaction kinds
	assign push_acc = s_tvalid && s_tready && (s_tuser == savgol_pkg::OP_PUSH);
	assign load_acc = s_tvalid && s_tready && (s_tuser == savgol_pkg::OP_LOAD);

	// a stalled result holds
	`SAVGOL_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

	// a push occupies the block for at least the next cycle
	`SAVGOL_ASSERT(a_push_busy, push_acc |=> !s_tready, "ready right after a push")

	// a weight load leaves the block ready
	`SAVGOL_ASSERT(a_load_quick, load_acc |=> s_tready, "busy after a weight load")

	// a new result only appears at the end of a busy period
	`SAVGOL_NEVER(a_out_rise, $rose(m_tvalid) && $past(s_tready), "result without a push in progress")

endmodule

bind savitzky_golay_fir savgol_checker u_savgol_checker (.*);
